FILE: rtl/vpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_pkg
// shared types and constants of the vgm psg command compactor
// ----------------------------------------------------------------------------
package vpc_pkg;

    typedef logic [7:0] t_byte;

    // parse phases
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_COMMAND  = 3'd1,
        PH_DROP_ARG = 3'd2,
        PH_PSG_DATA = 3'd3,
        PH_WAIT_LO  = 3'd4,
        PH_WAIT_HI  = 3'd5,
        PH_DONE     = 3'd6
    } t_phase;

    // vgm command codes
    localparam t_byte CMD_DROP_ARG = 8'h4F;
    localparam t_byte CMD_PSG      = 8'h50;
    localparam t_byte CMD_WAIT_N   = 8'h61;
    localparam t_byte CMD_FRAME_A  = 8'h62;
    localparam t_byte CMD_FRAME_B  = 8'h63;
    localparam t_byte CMD_END      = 8'h66;

    // compact output codes
    localparam t_byte WAIT_BASE = 8'h40;
    localparam t_byte END_MARK  = 8'h60;
    localparam t_byte PSG_MASK  = 8'h3F;

    // long wait divisor and its reciprocal (exact for 16-bit counts)
    localparam int WAIT_DIV   = 882 / 50;
    localparam int WAIT_SHIFT = 21;
    localparam int WAIT_RECIP = ((1 << WAIT_SHIFT) + WAIT_DIV - 1) / WAIT_DIV;
    localparam int WAIT_BITS  = 5;

    // configuration
    localparam int    APB_AW            = 3;
    localparam int    APB_DW            = 32;
    localparam t_byte HDR_LEN_RESET     = 8'd64;
    localparam logic [APB_AW-3:0] REG_HEADER_LENGTH = 1'b0;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        t_byte out_byte;
        logic  is_end;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/vpc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_in_if
// input channel: one vgm file byte per word
// ----------------------------------------------------------------------------
interface vpc_in_if;
    logic           valid;
    logic           ready;
    vpc_pkg::t_byte in_byte;
    logic           last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/vpc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_out_if
// output channel: one compact psg byte per word
// ----------------------------------------------------------------------------
interface vpc_out_if;
    logic           valid;
    logic           ready;
    vpc_pkg::t_byte out_byte;
    logic           is_end;

    modport source (output valid, output out_byte, output is_end, input ready);
    modport sink   (input valid, input out_byte, input is_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/vgm_psg_command_compactor.sv
`default_nettype none
// a result word is written into the result queue when its input word is accepted
// throughput: one input word per cycle, set by the single parse step per word, while
// the result queue has two free slots; an input word that yields two words
// (data or wait, then the end marker) writes both into the four-entry result queue
// reset (synchronous, i_rst_n low): header phase, counters clear, queue empty,
// header_length back to 64
// ----------------------------------------------------------------------------
// vgm_psg_command_compactor
// parses a vgm byte stream and emits compact psg data, wait and end bytes
// ----------------------------------------------------------------------------
module vgm_psg_command_compactor (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    vpc_in_if.sink                           i_in,
    vpc_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vpc_pkg::APB_AW-1:0]  paddr,
    input  wire logic [vpc_pkg::APB_DW-1:0]  pwdata,
    output logic      [vpc_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import vpc_pkg::*;

    // parse state
    t_phase           r_phase, n_phase;
    t_byte            r_hdr_cnt, n_hdr_cnt;
    t_byte            r_wait_lo, n_wait_lo;
    logic             r_done, n_done;
    t_byte            r_hdr_len;

    // result queue
    t_result          r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0]  r_count;

    logic             in_acc, out_acc, cfg_wr, cmd_hit;
    t_byte            b;
    logic [1:0]       res_cnt;
    t_result          res0, res1;
    logic [15:0]      wait_count;
    logic [31:0]      wait_prod;
    logic [WAIT_BITS-1:0] wait_n;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign b       = i_in.in_byte;

    assign i_in.ready     = (r_count <= Q_CW'(Q_DEPTH - 2));
    assign o_out.valid    = (r_count != '0);
    assign o_out.out_byte = r_q[r_rd_ptr].out_byte;
    assign o_out.is_end   = r_q[r_rd_ptr].is_end;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_HEADER_LENGTH);
    assign prdata = (paddr[APB_AW-1:2] == REG_HEADER_LENGTH) ?
                    {{(APB_DW-8){1'b0}}, r_hdr_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_len <= HDR_LEN_RESET;
        end else if (cfg_wr) begin
            r_hdr_len <= pwdata[7:0];
        end
    end

    // long wait: count / 17 by reciprocal multiply
    assign wait_count = {b, r_wait_lo};
    assign wait_prod  = 32'(wait_count) * 32'(WAIT_RECIP);
    assign wait_n     = wait_prod[WAIT_SHIFT +: WAIT_BITS];

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_wait_lo = r_wait_lo;
        n_done    = r_done;
        cmd_hit   = 1'b0;
        res_cnt   = 2'd0;
        res0      = '{out_byte: END_MARK, is_end: 1'b1};
        res1      = '{out_byte: END_MARK, is_end: 1'b1};

        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt < r_hdr_len) begin
                    n_hdr_cnt = r_hdr_cnt + 8'd1;
                end else begin
                    n_phase = PH_COMMAND;
                    cmd_hit = 1'b1;
                end
            end
            PH_COMMAND: begin
                cmd_hit = 1'b1;
            end
            PH_DROP_ARG: begin
                n_phase = PH_COMMAND;
            end
            PH_PSG_DATA: begin
                res0    = '{out_byte: (b[7] ? b : (b & PSG_MASK)), is_end: 1'b0};
                res_cnt = 2'd1;
                n_phase = PH_COMMAND;
            end
            PH_WAIT_LO: begin
                n_wait_lo = b;
                n_phase   = PH_WAIT_HI;
            end
            PH_WAIT_HI: begin
                if (wait_n != '0) begin
                    res0    = '{out_byte: WAIT_BASE + t_byte'(wait_n), is_end: 1'b0};
                    res_cnt = 2'd1;
                end
                n_phase = PH_COMMAND;
            end
            default: begin
                n_done  = 1'b1;
                n_phase = PH_DONE;
            end
        endcase

        if (cmd_hit) begin
            case (b)
                CMD_DROP_ARG: n_phase = PH_DROP_ARG;
                CMD_PSG:      n_phase = PH_PSG_DATA;
                CMD_WAIT_N:   n_phase = PH_WAIT_LO;
                CMD_FRAME_A, CMD_FRAME_B: begin
                    res0    = '{out_byte: WAIT_BASE, is_end: 1'b0};
                    res_cnt = 2'd1;
                end
                CMD_END: begin
                    res0    = '{out_byte: END_MARK, is_end: 1'b1};
                    res_cnt = 2'd1;
                    n_phase = PH_DONE;
                    n_done  = 1'b1;
                end
                default: begin
                    // short waits and unknown commands emit nothing
                end
            endcase
        end

        if (i_in.last_byte) begin
            // end marker appended at the next free slot unless already sent
            if (!n_done) begin
                res_cnt = res_cnt + 2'd1;
            end
            n_phase   = PH_HEADER;
            n_hdr_cnt = '0;
            n_wait_lo = '0;
            n_done    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_wait_lo <= '0;
            r_done    <= 1'b0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_wait_lo <= n_wait_lo;
            r_done    <= n_done;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc && (res_cnt != 2'd0)) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (in_acc && (res_cnt == 2'd2)) begin
            r_q[r_wr_ptr + Q_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(res_cnt);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= r_count + (in_acc ? Q_CW'(res_cnt) : '0) - Q_CW'(out_acc);
        end
    end

`ifndef NO_ASSERTIONS
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("result queue overflow");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last_byte) |=>
            (r_phase == PH_HEADER && r_hdr_cnt == '0 && !r_done))
        else $error("state not cleared after last byte");

    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_phase == PH_DONE))
        else $error("stream done outside done phase");

    a_two_ends_with_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_cnt == 2'd2) |-> (res1.is_end && !res0.is_end))
        else $error("second result is not the end marker");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_done) |-> (res_cnt == 2'd0))
        else $error("output after end of stream");
`endif

endmodule
`default_nettype wire
